>>> rtl/xcbc_pkg.sv
`default_nettype none

package xcbc_pkg;

	// XTEA constants
	localparam logic [31:0] XTEA_DELTA    = 32'h9E37_79B9;
	localparam int          ROUND_W       = 7;
	localparam logic [ROUND_W-1:0] RESET_ROUNDS = 7'd32;
	localparam logic [63:0] RESET_IV      = 64'hF309_8250_43BA_C344;
	localparam logic [31:0] RESET_DEC_SUM = 32'(64'(XTEA_DELTA) * 64'(RESET_ROUNDS));
	localparam int          CFG_IDX_W     = 3;

	// Operation codes carried by the mode field
	localparam logic MODE_ENC = 1'b0;
	localparam logic MODE_DEC = 1'b1;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_KEY0   = 3'd0,
		CFG_KEY1   = 3'd1,
		CFG_KEY2   = 3'd2,
		CFG_KEY3   = 3'd3,
		CFG_ROUNDS = 3'd4,
		CFG_IV     = 3'd5
	} cfg_idx_t;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_RUN  = 2'd1,
		ST_DONE = 2'd2
	} state_t;

	typedef logic [3:0][31:0] key_t;

	// Configuration seen by the datapath
	typedef struct packed {
		key_t               key;
		logic [ROUND_W-1:0] rounds;
		logic [31:0]        dec_sum;
		logic [63:0]        iv;
	} cfg_t;

	// XTEA mixing term
	function automatic logic [31:0] mix(input logic [31:0] x);
		return ((x << 4) ^ (x >> 5)) + x;
	endfunction

endpackage

`default_nettype wire

>>> rtl/xcbc_cfg.sv
`default_nettype none

module xcbc_cfg (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [xcbc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [63:0]                   cfg_data,
	output xcbc_pkg::cfg_t                     cfg
);

	xcbc_pkg::key_t                  key_q;
	logic [xcbc_pkg::ROUND_W-1:0]    rounds_q;
	logic [31:0]                     dec_sum_q;
	logic [63:0]                     iv_q;
	logic                            wr_en;
	logic [31:0]                     dec_sum_d;

	assign cfg_ready = 1'b1;
	assign wr_en     = cfg_valid && cfg_ready;

	// Starting sum for decryption: delta times the round count, modulo 2^32
	assign dec_sum_d = 32'(32'(cfg_data[xcbc_pkg::ROUND_W-1:0]) * xcbc_pkg::XTEA_DELTA);

	// Register file; writes beyond the last register are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q     <= '0;
			rounds_q  <= xcbc_pkg::RESET_ROUNDS;
			dec_sum_q <= xcbc_pkg::RESET_DEC_SUM;
			iv_q      <= xcbc_pkg::RESET_IV;
		end else if (wr_en) begin
			case (cfg_index)
				xcbc_pkg::CFG_KEY0: key_q[0] <= cfg_data[31:0];
				xcbc_pkg::CFG_KEY1: key_q[1] <= cfg_data[31:0];
				xcbc_pkg::CFG_KEY2: key_q[2] <= cfg_data[31:0];
				xcbc_pkg::CFG_KEY3: key_q[3] <= cfg_data[31:0];
				xcbc_pkg::CFG_ROUNDS: begin
					rounds_q  <= cfg_data[xcbc_pkg::ROUND_W-1:0];
					dec_sum_q <= dec_sum_d;
				end
				xcbc_pkg::CFG_IV: iv_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = '{key: key_q, rounds: rounds_q, dec_sum: dec_sum_q, iv: iv_q};

endmodule

`default_nettype wire

>>> rtl/xcbc_round.sv
`default_nettype none

module xcbc_round (
	input  wire logic           mode,
	input  wire xcbc_pkg::key_t key,
	input  wire logic [63:0]    v,
	input  wire logic [31:0]    sum,
	output logic [63:0]         v_next,
	output logic [31:0]         sum_next
);

	logic [31:0] a;
	logic [31:0] b;
	logic [31:0] enc_a;
	logic [31:0] enc_b;
	logic [31:0] enc_s;
	logic [31:0] dec_a;
	logic [31:0] dec_b;
	logic [31:0] dec_s;

	assign a = v[31:0];
	assign b = v[63:32];

	// One full encryption cycle: update a, advance sum, update b
	always_comb begin
		enc_a = a + (xcbc_pkg::mix(b) ^ (sum + key[sum[1:0]]));
		enc_s = sum + xcbc_pkg::XTEA_DELTA;
		enc_b = b + (xcbc_pkg::mix(enc_a) ^ (enc_s + key[enc_s[12:11]]));
	end

	// One full decryption cycle: undo b, step sum back, undo a
	always_comb begin
		dec_b = b - (xcbc_pkg::mix(a) ^ (sum + key[sum[12:11]]));
		dec_s = sum - xcbc_pkg::XTEA_DELTA;
		dec_a = a - (xcbc_pkg::mix(dec_b) ^ (dec_s + key[dec_s[1:0]]));
	end

	// Select direction
	always_comb begin
		if (mode == xcbc_pkg::MODE_DEC) begin
			v_next   = {dec_b, dec_a};
			sum_next = dec_s;
		end else begin
			v_next   = {enc_b, enc_a};
			sum_next = enc_s;
		end
	end

endmodule

`default_nettype wire

>>> rtl/xtea_cbc_block_cipher.sv
// XTEA in CBC mode, one 64-bit block per beat (low word is the first half).
// mode 0 encrypts, mode 1 decrypts; first_block reloads the chain from the
// configured initial vector. A single round unit runs one full XTEA cycle per
// clock, so a block goes through loading, the rounds and the finish step
// before its result is registered, and one block is worked at a time; the
// next block is taken only once the previous result has been registered. A
// finished result waits in the output register while the next block is
// accepted. The configuration port is always ready; write it only while no
// block is in flight.
`default_nettype none

module xtea_cbc_block_cipher (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [xcbc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [63:0]                    cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic                           mode,
	input  wire logic                           first_block,
	input  wire logic [63:0]                    block_in,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [63:0]                         block_out
);

	xcbc_pkg::cfg_t               cfg;
	xcbc_pkg::state_t             state_q;
	xcbc_pkg::state_t             state_d;
	logic [xcbc_pkg::ROUND_W-1:0] cnt_q;
	logic [63:0]                  v_q;
	logic [31:0]                  sum_q;
	logic [63:0]                  xor_q;
	logic                         mode_q;
	logic [63:0]                  chain_q;
	logic [63:0]                  out_q;
	logic                         out_valid_q;
	logic [63:0]                  v_next;
	logic [31:0]                  sum_next;
	logic [63:0]                  chain_sel;
	logic [63:0]                  result;
	logic                         in_acc;
	logic                         step_en;
	logic                         finish;
	logic                         slot_free;

	xcbc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	xcbc_round u_round (
		.mode     (mode_q),
		.key      (cfg.key),
		.v        (v_q),
		.sum      (sum_q),
		.v_next   (v_next),
		.sum_next (sum_next)
	);

	assign in_acc    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign chain_sel = first_block ? cfg.iv : chain_q;
	assign result    = v_q ^ xor_q;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			xcbc_pkg::ST_IDLE: begin
				if (in_acc) state_d = xcbc_pkg::ST_RUN;
			end
			xcbc_pkg::ST_RUN: begin
				if (cnt_q == '0) state_d = xcbc_pkg::ST_DONE;
			end
			xcbc_pkg::ST_DONE: begin
				if (slot_free) state_d = xcbc_pkg::ST_IDLE;
			end
			default: state_d = xcbc_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		in_ready = 1'b0;
		step_en  = 1'b0;
		finish   = 1'b0;
		case (state_q)
			xcbc_pkg::ST_IDLE: in_ready = 1'b1;
			xcbc_pkg::ST_RUN:  step_en  = (cnt_q != '0);
			xcbc_pkg::ST_DONE: finish   = slot_free;
			default: ;
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= xcbc_pkg::ST_IDLE;
			cnt_q       <= '0;
			chain_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// load the round count, then count down one per cycle
			if (in_acc) begin
				cnt_q <= cfg.rounds;
			end else if (step_en) begin
				cnt_q <= cnt_q - xcbc_pkg::ROUND_W'(1);
			end
			// decryption chains on the incoming ciphertext, encryption on its result
			if (in_acc && mode == xcbc_pkg::MODE_DEC) begin
				chain_q <= block_in;
			end else if (finish && mode_q == xcbc_pkg::MODE_ENC) begin
				chain_q <= result;
			end
			// output register valid
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			mode_q <= mode;
			if (mode == xcbc_pkg::MODE_DEC) begin
				v_q   <= block_in;
				sum_q <= cfg.dec_sum;
				xor_q <= chain_sel;
			end else begin
				v_q   <= block_in ^ chain_sel;
				sum_q <= '0;
				xor_q <= '0;
			end
		end else if (step_en) begin
			v_q   <= v_next;
			sum_q <= sum_next;
		end
		if (finish) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign block_out = out_q;

endmodule

`default_nettype wire

>>> rtl/xcbc_checker.sv
`default_nettype none

module xcbc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [63:0] block_out
);

	logic [1:0] pend_q;
	logic       in_beat;
	logic       out_beat;

	assign in_beat  = in_valid && in_ready;
	assign out_beat = out_valid && out_ready;

	// Track blocks accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 2'(in_beat) - 2'(out_beat);
		end
	end

	// One block at a time: input closes right after a beat
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> !in_ready)
		else $error("input accepted while a block is in flight");

	// No result without an accepted block
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 2'd0)
		else $error("result shown with no block outstanding");

	// At most one finished and one running block
	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("too many blocks outstanding");

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(block_out))
		else $error("stalled result changed");

endmodule

bind xtea_cbc_block_cipher xcbc_checker u_xcbc_checker (.*);

`default_nettype wire
